FILE: hdl/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EXLEX_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("exlex check failed");
`define EXLEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("exlex check failed");
`else
`define EXLEX_ASSERT(label, clk, rst, prop)
`define EXLEX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/exlex_pkg.sv
// Types, codes and character helpers for the expression lexer.
// No dependencies; imported by expression_lexer_unit.
package exlex_pkg;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] K_KEYWORD = 4'd0;
  localparam logic [3:0] K_IDENT   = 4'd1;
  localparam logic [3:0] K_NUMBER  = 4'd2;
  localparam logic [3:0] K_ARITH   = 4'd3;
  localparam logic [3:0] K_ASSIGN  = 4'd4;
  localparam logic [3:0] K_LPAREN  = 4'd5;
  localparam logic [3:0] K_RPAREN  = 4'd6;
  localparam logic [3:0] K_COMMA   = 4'd7;
  localparam logic [3:0] K_INVALID = 4'd8;
  localparam logic [3:0] K_END     = 4'd9;

  localparam logic [2:0] KW_LEN = 3'd6;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } src_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic        is_last;
  } tok_t;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_IDENT = 5'b00010,
    M_NUM   = 5'b00100,
    M_MINUS = 5'b01000,
    M_STOP  = 5'b10000
  } mode_t;

  function automatic logic [7:0] kw_char(logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = "f";
      3'd1:    c = "u";
      3'd2:    c = "n";
      3'd3:    c = "c";
      3'd4:    c = "a";
      3'd5:    c = "o";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [3:0] single_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      "+", "*", "/", "^": k = K_ARITH;
      "=":                k = K_ASSIGN;
      "(":                k = K_LPAREN;
      ")":                k = K_RPAREN;
      ",":                k = K_COMMA;
      default:            k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] clip16(logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [23:0] clip24(logic [31:0] v);
    return (v > 32'h00FF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

endpackage

FILE: hdl/expression_lexer_unit.sv
// Streaming lexer for a small expression language: bytes in, token descriptors out.
// Depends on exlex_pkg and assert_macros.svh.
//
// Each request carries one source byte (op = char) or the end-of-source marker
// (op = end). A request is held in an input register; once the queue holds at
// most two entries, one pass of logic updates the lexer state and pushes zero,
// one or two token descriptors into a four-entry result queue. A new request
// can be taken every cycle while the queue holds at most two entries, so
// requests that each yield at most one token stream at one per cycle while
// tok_stall is low; a request that yields two tokens (a pending token flushed
// by a single-character token, or the end token after a pending one) fills the
// queue faster than the single queue read port drains it. A zero byte flushes
// and stops lexing until the end marker, which emits the end token and returns
// the lexer state and positions to reset values. Positions and lengths saturate.
`include "assert_macros.svh"
module expression_lexer_unit import exlex_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 24,
  parameter int LEN_BITS    = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  src_t src,
  output logic tok_valid,
  input  logic tok_stall,
  output tok_t tok
);

  localparam int DEPTH = 4;

  // input register
  logic in_full;
  src_t in_req;

  // lexer state
  mode_t                  mode, mode_next;
  logic                   dot_seen, dot_seen_next;
  logic [2:0]             kw_prog, kw_prog_next;
  logic                   kw_miss, kw_miss_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COL_BITS-1:0]    cur_column, cur_column_next;
  logic [OFFSET_BITS-1:0] cur_offset, cur_offset_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COL_BITS-1:0]    tok_column, tok_column_next;
  logic [OFFSET_BITS-1:0] tok_offset, tok_offset_next;
  logic [LEN_BITS-1:0]    tok_len, tok_len_next;
  logic [7:0]             tok_first, tok_first_next;

  // result queue
  tok_t       queue [DEPTH];
  logic [1:0] head, tail;
  logic [2:0] cnt;

  logic proc, pop;
  logic a_v, b_v;
  tok_t a_tok, b_tok;

  // process the held request only when two queue slots are certain to be free
  assign proc      = in_full && (cnt <= 3'(DEPTH - 2));
  assign src_stall = in_full && !proc;
  assign tok_valid = (cnt != 3'd0);
  assign tok       = queue[head];
  assign pop       = tok_valid && !tok_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (src_valid && !src_stall) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
    if (src_valid && !src_stall) begin
      in_req <= src;
    end
  end

  // one lexing step: flush candidate in a, new token or end token in b
  always_comb begin
    logic [7:0] c;
    logic       fl_v;
    logic [3:0] fl_kind;
    logic       ext;
    logic       do_adv;
    logic       kw_hit;

    c       = in_req.ch;
    fl_v    = 1'b0;
    fl_kind = K_INVALID;
    unique case (mode)
      M_IDENT: begin
        fl_v    = 1'b1;
        fl_kind = (!kw_miss && kw_prog == KW_LEN) ? K_KEYWORD : K_IDENT;
      end
      M_NUM: begin
        fl_v    = 1'b1;
        fl_kind = K_NUMBER;
      end
      M_MINUS: begin
        fl_v    = 1'b1;
        fl_kind = K_ARITH;
      end
      M_IDLE, M_STOP: begin
        fl_v = 1'b0;
      end
      default: begin
        fl_v = 1'b0;
      end
    endcase

    a_tok.token_kind   = fl_kind;
    a_tok.start_line   = clip16(32'(tok_line));
    a_tok.start_column = clip16(32'(tok_column));
    a_tok.start_offset = clip24(32'(tok_offset));
    a_tok.token_length = clip16(32'(tok_len));
    a_tok.first_char   = tok_first;
    a_tok.is_last      = 1'b0;

    b_tok.token_kind   = single_kind(c);
    b_tok.start_line   = clip16(32'(cur_line));
    b_tok.start_column = clip16(32'(cur_column));
    b_tok.start_offset = clip24(32'(cur_offset));
    b_tok.token_length = 16'd1;
    b_tok.first_char   = c;
    b_tok.is_last      = 1'b0;

    a_v    = 1'b0;
    b_v    = 1'b0;
    do_adv = 1'b0;
    kw_hit = !kw_miss && (kw_prog < KW_LEN) && (c == kw_char(kw_prog));

    mode_next       = mode;
    dot_seen_next   = dot_seen;
    kw_prog_next    = kw_prog;
    kw_miss_next    = kw_miss;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    tok_offset_next = tok_offset;
    tok_len_next    = tok_len;
    tok_first_next  = tok_first;

    ext = ((mode == M_IDENT) && (is_alpha(c) || is_digit(c) || c == "_")) ||
          ((mode == M_NUM) && (is_digit(c) || (!dot_seen && c == "."))) ||
          ((mode == M_MINUS) && is_digit(c));

    if (in_req.op == OP_END) begin
      // flush, emit end token, then return to the reset state
      a_v                = fl_v;
      b_v                = 1'b1;
      b_tok.token_kind   = K_END;
      b_tok.token_length = 16'd0;
      b_tok.first_char   = 8'h00;
      b_tok.is_last      = 1'b1;
      mode_next          = M_IDLE;
      dot_seen_next      = 1'b0;
      kw_prog_next       = 3'd0;
      kw_miss_next       = 1'b0;
      tok_line_next      = '0;
      tok_column_next    = '0;
      tok_offset_next    = '0;
      tok_len_next       = '0;
      tok_first_next     = 8'h00;
    end else if (mode == M_STOP) begin
      // drop bytes after a zero byte
      a_v = 1'b0;
    end else if (c == 8'h00) begin
      a_v       = fl_v;
      mode_next = M_STOP;
    end else if (ext) begin
      do_adv       = 1'b1;
      tok_len_next = (tok_len == '1) ? tok_len : tok_len + 1'b1;
      if (mode == M_IDENT) begin
        if (kw_hit) begin
          kw_prog_next = kw_prog + 3'd1;
        end else begin
          kw_miss_next = 1'b1;
        end
      end else if (mode == M_NUM) begin
        if (c == ".") begin
          dot_seen_next = 1'b1;
        end
      end else begin
        mode_next     = M_NUM;
        dot_seen_next = 1'b0;
      end
    end else begin
      a_v       = fl_v;
      mode_next = M_IDLE;
      do_adv    = 1'b1;
      if (!is_space(c)) begin
        tok_line_next   = cur_line;
        tok_column_next = cur_column;
        tok_offset_next = cur_offset;
        tok_len_next    = LEN_BITS'(1);
        tok_first_next  = c;
        if (is_alpha(c)) begin
          mode_next    = M_IDENT;
          kw_prog_next = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
          kw_miss_next = (c != kw_char(3'd0));
        end else if (is_digit(c)) begin
          mode_next     = M_NUM;
          dot_seen_next = 1'b0;
        end else if (c == "-") begin
          mode_next = M_MINUS;
        end else begin
          b_v = 1'b1;
        end
      end
    end

    // advance position
    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    cur_offset_next = cur_offset;
    if (in_req.op == OP_END) begin
      cur_line_next   = LINE_BITS'(1);
      cur_column_next = COL_BITS'(1);
      cur_offset_next = '0;
    end else if (do_adv) begin
      cur_offset_next = (cur_offset == '1) ? cur_offset : cur_offset + 1'b1;
      if (c == 8'h0A) begin
        cur_line_next   = (cur_line == '1) ? cur_line : cur_line + 1'b1;
        cur_column_next = COL_BITS'(1);
      end else begin
        cur_column_next = (cur_column == '1) ? cur_column : cur_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      dot_seen   <= 1'b0;
      kw_prog    <= 3'd0;
      kw_miss    <= 1'b0;
      cur_line   <= LINE_BITS'(1);
      cur_column <= COL_BITS'(1);
      cur_offset <= '0;
    end else if (proc) begin
      mode       <= mode_next;
      dot_seen   <= dot_seen_next;
      kw_prog    <= kw_prog_next;
      kw_miss    <= kw_miss_next;
      cur_line   <= cur_line_next;
      cur_column <= cur_column_next;
      cur_offset <= cur_offset_next;
    end
    if (proc) begin
      tok_line   <= tok_line_next;
      tok_column <= tok_column_next;
      tok_offset <= tok_offset_next;
      tok_len    <= tok_len_next;
      tok_first  <= tok_first_next;
    end
  end

  // result queue: up to two pushes and one pop per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 2'd0;
      tail <= 2'd0;
      cnt  <= 3'd0;
    end else begin
      head <= pop ? head + 2'd1 : head;
      tail <= proc ? tail + 2'(a_v) + 2'(b_v) : tail;
      cnt  <= cnt + (proc ? 3'(a_v) + 3'(b_v) : 3'd0) - 3'(pop);
    end
    if (proc && a_v) begin
      queue[tail] <= a_tok;
    end
    if (proc && b_v) begin
      queue[tail + 2'(a_v)] <= b_tok;
    end
  end

  `EXLEX_ASSERT(a_queue_bound, clk, rst, cnt <= 3'(DEPTH))
  `EXLEX_ASSERT(a_stop_silent, clk, rst, (proc && mode == M_STOP && in_req.op == OP_CHAR) |-> (!a_v && !b_v))
  `EXLEX_ASSERT_NEXT(a_end_resets, clk, rst, proc && in_req.op == OP_END, mode == M_IDLE && cur_offset == '0 && cnt != 3'd0)

endmodule
